// File: rtl/abpagc_pkg.sv
// shared types and constants for the block peak agc
// no dependencies
package abpagc_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int SCALE_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;
	localparam int DIV_NW    = 32;
	localparam int DIV_DW    = 40;

	localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_VOL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd3;

	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_SLOW   = 3'd1;
	localparam logic [2:0] MODE_FAST   = 3'd2;
	localparam logic [2:0] MODE_DOWN   = 3'd3;
	localparam logic [2:0] MODE_SPIKE  = 3'd4;

	localparam logic [2:0]  RST_MODE   = MODE_SPIKE;
	localparam logic [6:0]  RST_SMOOTH = 7'd90;
	localparam logic [7:0]  RST_VOL    = 8'd255;
	localparam logic [19:0] RST_WINDOW = 20'd11025;
	localparam logic [15:0] RST_TARGET = 16'd220;
	localparam logic [15:0] RST_SCALE  = 16'd100;

	// 40 * 32767
	localparam logic [20:0] NUM_GAIN   = 21'd1310680;

	localparam logic [3:0] STEP_NONE   = 4'd0;
	localparam logic [3:0] STEP_PREP   = 4'd1;
	localparam logic [3:0] STEP_SP     = 4'd2;
	localparam logic [3:0] STEP_SPIKE  = 4'd3;
	localparam logic [3:0] STEP_FILT   = 4'd4;
	localparam logic [3:0] STEP_TGT    = 4'd5;
	localparam logic [3:0] STEP_FOLLOW = 4'd6;
	localparam logic [3:0] STEP_SCALE  = 4'd7;
	localparam logic [3:0] STEP_FIN    = 4'd8;

	typedef struct packed {
		logic       take;
		logic [3:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic upd_go;
		logic calc_ok;
		logic filt_div;
		logic follow_div;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/abpagc_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on abpagc_pkg
module abpagc_div import abpagc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] dvd_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	assign trial = {rem_q, dvd_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
			dvd_q <= {dvd_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: rtl/abpagc_dp.sv
// datapath: block min/max tracking, countdown, target filter and scale follow
// depends on abpagc_pkg and abpagc_div
module abpagc_dp import abpagc_pkg::*; #(
	parameter int COUNT_WIDTH = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 block_end,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [SCALE_W-1:0]   scale_percent,
	output logic                 scale_updated
);

	logic [2:0]  mode_q;
	logic [6:0]  smooth_q;
	logic [7:0]  vol_q;
	logic [19:0] window_q;

	logic [SAMPLE_W-1:0]    max_q, min_q;
	logic [COUNT_WIDTH-1:0] len_q, cnt_q;
	logic [15:0]            t_q, s_q;
	logic [7:0]             spike_q;
	logic [29:0]            sp_q;
	logic                   add_q;
	logic                   out_valid_q, upd_out_q;
	logic [15:0]            out_scale_q;

	logic                   first, newlen_max;
	logic [SAMPLE_W-1:0]    nmax, nmin;
	logic [COUNT_WIDTH-1:0] newlen, reload;
	logic [32:0]            win_ext, cmax_ext;
	logic [6:0]             f_eff;
	logic [2:0]             f_div20;
	logic [31:0]            amx, amn, peak;
	logic [32:0]            delta;
	logic [28:0]            num;
	logic [39:0]            den;
	logic signed [30:0]     diff;
	logic [29:0]            sp_f;
	logic                   s_gt_t, repl, addp;
	logic [22:0]            wsum;
	logic                   hit;
	logic [7:0]             spike_n;
	logic                   div_start, div_done;
	logic [DIV_NW-1:0]      dvd, quo;
	logic [DIV_DW-1:0]      dvs;
	logic [16:0]            t_sum;
	logic [34:0]            s_sum;
	logic                   out_free;

	// block tracking
	assign first      = len_q == '0;
	assign nmax       = (first || $signed(sample) > $signed(max_q)) ? sample : max_q;
	assign nmin       = (first || $signed(sample) < $signed(min_q)) ? sample : min_q;
	assign newlen_max = &len_q;
	assign newlen     = newlen_max ? len_q : len_q + 1'b1;
	assign win_ext    = 33'(window_q);
	assign cmax_ext   = {{(33-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
	assign reload     = (win_ext > cmax_ext) ? {COUNT_WIDTH{1'b1}}
	                                         : win_ext[COUNT_WIDTH-1:0];

	// effective smoothing and its twentieth
	always_comb begin
		if (smooth_q == 7'd0)        f_eff = 7'd1;
		else if (smooth_q > 7'd100)  f_eff = 7'd100;
		else                         f_eff = smooth_q;
		if (f_eff >= 7'd100)         f_div20 = 3'd5;
		else if (f_eff >= 7'd80)     f_div20 = 3'd4;
		else if (f_eff >= 7'd60)     f_div20 = 3'd3;
		else if (f_eff >= 7'd40)     f_div20 = 3'd2;
		else if (f_eff >= 7'd20)     f_div20 = 3'd1;
		else                         f_div20 = 3'd0;
	end

	// peak and swing of the finished block
	assign amx   = max_q[31] ? (~max_q + 32'd1) : max_q;
	assign amn   = min_q[31] ? (~min_q + 32'd1) : min_q;
	assign peak  = (amx > amn) ? amx : amn;
	assign delta = {max_q[31], max_q} - {min_q[31], min_q};
	assign num   = 29'(vol_q) * 29'(NUM_GAIN);
	assign den   = 40'(peak) * 40'd255;

	// jump limit
	assign diff = $signed({1'b0, sp_q}) - $signed({15'd0, t_q});
	assign sp_f = (diff > 31'sd1000) ? 30'(t_q) + 30'd50 : sp_q;

	// follow mode decode
	assign s_gt_t = s_q > t_q;
	assign repl   = (mode_q == MODE_FAST) ||
	                ((mode_q == MODE_SLOW || mode_q == MODE_SPIKE || mode_q == MODE_DOWN)
	                 && s_gt_t);
	assign addp   = (mode_q == MODE_SLOW || mode_q == MODE_SPIKE) && !s_gt_t;
	assign wsum   = 23'(f_eff) * 23'(s_q) + 23'(7'd100 - f_eff) * 23'(t_q);

	// spike counter
	assign hit     = (sp_q > 30'(t_q)) && ((sp_q - 30'(t_q)) > 30'd500);
	assign spike_n = hit ? ((spike_q == 8'hFF) ? spike_q : spike_q + 8'd1) : 8'd0;

	always_comb begin
		div_start = 1'b0;
		dvd       = '0;
		dvs       = DIV_DW'(1);
		case (cmd.step)
			STEP_PREP: begin
				div_start = sts.calc_ok;
				dvd       = DIV_NW'(num);
				dvs       = den;
			end
			STEP_FILT: begin
				div_start = sts.filt_div;
				dvd       = DIV_NW'(sp_f - 30'(t_q));
				dvs       = DIV_DW'(10);
			end
			STEP_FOLLOW: begin
				div_start = repl || addp;
				if (repl) begin
					dvd = DIV_NW'(wsum);
					dvs = DIV_DW'(100);
				end else begin
					dvd = DIV_NW'(t_q - s_q);
					dvs = DIV_DW'(f_eff);
				end
			end
			default: ;
		endcase
	end

	abpagc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	assign t_sum    = {1'b0, t_q} + 17'(quo);
	assign s_sum    = 35'(s_q) + 35'(quo) * 35'd5;
	assign out_free = !out_valid_q || out_ready;

	assign sts.upd_go     = block_end && (cnt_q <= newlen);
	assign sts.calc_ok    = (peak != 32'd0) && !delta[32] && (|delta[31:14]);
	assign sts.filt_div   = sp_f > 30'(t_q);
	assign sts.follow_div = repl || addp;
	assign sts.div_done   = div_done;
	assign sts.out_free   = out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_MODE;
			smooth_q <= RST_SMOOTH;
			vol_q    <= RST_VOL;
			window_q <= RST_WINDOW;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FOLLOW_MODE: mode_q   <= cfg_data[2:0];
				REG_SMOOTHING:   smooth_q <= cfg_data[6:0];
				REG_CHANNEL_VOL: vol_q    <= cfg_data[7:0];
				REG_WINDOW:      window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// block state and update chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			cnt_q   <= '0;
			t_q     <= RST_TARGET;
			s_q     <= RST_SCALE;
			spike_q <= '0;
			max_q   <= '0;
			min_q   <= '0;
		end else begin
			if (cmd.take) begin
				max_q <= nmax;
				min_q <= nmin;
				if (block_end) begin
					len_q <= '0;
					cnt_q <= sts.upd_go ? reload : cnt_q - newlen;
				end else begin
					len_q <= newlen;
				end
			end
			case (cmd.step)
				STEP_SPIKE: begin
					if (mode_q == MODE_SPIKE) begin
						spike_q <= spike_n;
						if (spike_n == 8'(f_div20))
							t_q <= (sp_q > 30'hFFFF) ? 16'hFFFF : sp_q[15:0];
					end
				end
				STEP_FILT: begin
					if (!sts.filt_div)
						t_q <= sp_f[15:0];
				end
				STEP_TGT:   t_q <= t_sum[16] ? 16'hFFFF : t_sum[15:0];
				STEP_SCALE: begin
					if (add_q)
						s_q <= (|s_sum[34:16]) ? 16'hFFFF : s_sum[15:0];
					else
						s_q <= quo[15:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_PREP:   if (!sts.calc_ok) sp_q <= 30'(t_q);
			STEP_SP:     sp_q <= (quo >= 32'd110) ? 30'(quo - 32'd10) : 30'(quo);
			STEP_FOLLOW: add_q <= addp;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step == STEP_FIN ||
		             (cmd.take && block_end && !sts.upd_go)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step == STEP_FIN) begin
			out_scale_q <= s_q;
			upd_out_q   <= 1'b1;
		end else if (cmd.take && block_end && !sts.upd_go) begin
			out_scale_q <= s_q;
			upd_out_q   <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign scale_percent = out_scale_q;
	assign scale_updated = upd_out_q;

endmodule

// File: rtl/abpagc_ctrl.sv
// controller: sequences the scale update over the shared divider
// depends on abpagc_pkg
module abpagc_ctrl import abpagc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    block_end,
	output logic    in_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_WSP    = 4'd2;
	localparam logic [3:0] S_SPIKE  = 4'd3;
	localparam logic [3:0] S_FILT   = 4'd4;
	localparam logic [3:0] S_WT     = 4'd5;
	localparam logic [3:0] S_FOLLOW = 4'd6;
	localparam logic [3:0] S_WS     = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q, state_n;
	logic       take;

	assign in_ready = (state_q == S_IDLE) && (!block_end || sts.out_free);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_n  = state_q;
		cmd.take = take;
		cmd.step = STEP_NONE;
		unique case (state_q)
			S_IDLE:   if (take && sts.upd_go) state_n = S_PREP;
			S_PREP: begin
				cmd.step = STEP_PREP;
				state_n  = sts.calc_ok ? S_WSP : S_FILT;
			end
			S_WSP: if (sts.div_done) begin
				cmd.step = STEP_SP;
				state_n  = S_SPIKE;
			end
			S_SPIKE: begin
				cmd.step = STEP_SPIKE;
				state_n  = S_FILT;
			end
			S_FILT: begin
				cmd.step = STEP_FILT;
				state_n  = sts.filt_div ? S_WT : S_FOLLOW;
			end
			S_WT: if (sts.div_done) begin
				cmd.step = STEP_TGT;
				state_n  = S_FOLLOW;
			end
			S_FOLLOW: begin
				cmd.step = STEP_FOLLOW;
				state_n  = sts.follow_div ? S_WS : S_DONE;
			end
			S_WS: if (sts.div_done) begin
				cmd.step = STEP_SCALE;
				state_n  = S_DONE;
			end
			S_DONE: begin
				cmd.step = STEP_FIN;
				state_n  = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_n;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("input ready outside idle");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> sts.out_free)
		else $error("result slot busy at update end");

	a_prep_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PREP |=> state_q == S_WSP || state_q == S_FILT)
		else $error("bad step after prep");

	a_upd_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && sts.upd_go |=> state_q == S_PREP)
		else $error("update not started");

endmodule

// File: rtl/audio_block_peak_agc_unit.sv
// top level of the block peak agc: controller, datapath and divider
// depends on abpagc_pkg, abpagc_ctrl, abpagc_dp
//
// usage:
//  - input (in_valid/in_ready, sample, block_end) takes one audio sample
//    per cycle while in_ready is high; block_end marks a block's last sample
//  - each block end gives one item on the output channel (out_valid/out_ready,
//    scale_percent, scale_updated); other samples give none
//  - a block end whose countdown has not run out yields its item in the
//    cycle after acceptance and the input keeps flowing
//  - a block end that runs the scale update holds in_ready low while the
//    update runs: up to three divisions on the shared divider, each with a
//    wait step that hands back its quotient, plus the prep, spike, filter,
//    follow and done steps; the item is valid once the done step has run
//  - a block end is held off while an earlier item still sits unread in
//    the output register; plain samples are taken regardless
//  - configuration writes (cfg_we, cfg_idx, cfg_data) land at once and are
//    meant for idle periods only
//  - reset clears the countdown, block length and spike count, and loads
//    target 220, scale 100 and the register reset values
module audio_block_peak_agc_unit import abpagc_pkg::*; #(
	parameter int COUNT_WIDTH = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 block_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SCALE_W-1:0]   scale_percent,
	output logic                 scale_updated,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer for the update chain
	abpagc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.block_end (block_end),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// tracking, filtering and result register
	abpagc_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample        (sample),
		.block_end     (block_end),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.scale_percent (scale_percent),
		.scale_updated (scale_updated)
	);

endmodule

// File: tb/sv/testbench.sv
// testbench for audio_block_peak_agc_unit: a scoreboard class predicts each block-end result
// depends on abpagc_pkg and the rtl of audio_block_peak_agc_unit
`timescale 1ns / 100ps

module testbench;
	import abpagc_pkg::*;

	localparam int CNT_W = 20;
	localparam longint CNT_MAX = (64'd1 << CNT_W) - 1;

	// mirror of the agc: config registers, block tracking and scale state
	class agc_scoreboard;
		bit [2:0]  mode;
		bit [6:0]  smooth;
		bit [7:0]  vol;
		bit [19:0] window;
		longint    blk_max, blk_min, blk_len, countdown, target, scale;
		int        spikes;
		int        errors;
		bit [16:0] scale_q[$];   // expected {scale_percent, scale_updated}

		function new();
			mode = RST_MODE; smooth = RST_SMOOTH; vol = RST_VOL; window = RST_WINDOW;
			blk_max = 0; blk_min = 0; blk_len = 0; countdown = 0;
			target = 220; scale = 100; spikes = 0; errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
			case (idx)
				REG_FOLLOW_MODE: mode = d[2:0];
				REG_SMOOTHING:   smooth = d[6:0];
				REG_CHANNEL_VOL: vol = d[7:0];
				REG_WINDOW:      window = d[19:0];
				default: ;
			endcase
		endfunction

		function longint clip16(longint v);
			if (v < 0) return 0;
			if (v > 65535) return 65535;
			return v;
		endfunction

		function longint blend(longint f, longint s, longint t);
			return (f * s + (100 - f) * t) / 100;
		endfunction

		// set point, spike count, target filter and follow step, run when the countdown has expired
		function void update_scale();
			longint f, delta, amx, amn, peak, sp, s, t;
			f = smooth;
			if (f < 1) f = 1;
			if (f > 100) f = 100;
			delta = blk_max - blk_min;
			amx = blk_max < 0 ? -blk_max : blk_max;
			amn = blk_min < 0 ? -blk_min : blk_min;
			peak = amx > amn ? amx : amn;
			sp = target;
			s = scale;
			if (peak != 0 && delta >= 16384) begin
				sp = (40 * longint'(vol) * 32767) / (peak * 255);
				if (sp >= 110) sp -= 10;
				if (mode == MODE_SPIKE) begin
					// spike counter only counts large upward jumps
					if (target < sp && sp - target > 500) begin
						if (spikes < 255) spikes++;
					end else begin
						spikes = 0;
					end
					if (spikes == f / 20) target = sp;
				end
			end
			if (sp - target > 1000) sp = target + 50;
			if (sp <= target) target = sp;
			else target += (sp - target) / 10;
			target = clip16(target);
			t = target;
			case (mode)
				MODE_SLOW, MODE_SPIKE: begin
					if (s > t) s = blend(f, s, t);
					else s += (t - s) / f * 5;
				end
				MODE_FAST: s = blend(f, s, t);
				MODE_DOWN: if (s > t) s = blend(f, s, t);
				default: ;
			endcase
			scale = clip16(s);
		endfunction

		function void note_input(logic [31:0] smp, logic last);
			longint v;
			bit upd;
			v = longint'($signed(smp));
			if (blk_len == 0) begin
				blk_max = v; blk_min = v;
			end else begin
				if (v > blk_max) blk_max = v;
				if (v < blk_min) blk_min = v;
			end
			if (blk_len < CNT_MAX) blk_len++;
			if (!last) return;
			upd = 0;
			if (countdown <= blk_len) begin
				countdown = window;
				update_scale();
				upd = 1;
			end else begin
				countdown -= blk_len;
			end
			blk_len = 0;
			scale_q.push_back({scale[15:0], upd});
		endfunction

		function void check(logic [15:0] sp, logic up);
			bit [16:0] exp_item;
			if (scale_q.size() == 0) begin
				$error("unexpected item: scale_percent %0d scale_updated %0d", sp, up);
				errors++;
				return;
			end
			exp_item = scale_q.pop_front();
			if (sp !== exp_item[16:1]) begin
				$error("scale_percent expected %0d actual %0d", exp_item[16:1], sp);
				errors++;
			end
			if (up !== exp_item[0]) begin
				$error("scale_updated expected %0d actual %0d", exp_item[0], up);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 block_end = 0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic [SCALE_W-1:0]   scale_percent;
	logic                 scale_updated;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	agc_scoreboard sb = new();
	bit tx_burst;      // sender offers back to back when set
	bit rx_burst;      // receiver always ready when set
	bit rx_hold_req;   // receiver does one long hold-off
	bit stim_done;

	always #6 clk = ~clk;

	audio_block_peak_agc_unit #(.COUNT_WIDTH(CNT_W)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample(sample), .block_end(block_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.scale_percent(scale_percent), .scale_updated(scale_updated),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// both handshakes sampled at the edge, before any driver update lands
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(sample, block_end);
		if (arst_n && out_valid && out_ready) sb.check(scale_percent, scale_updated);
	end

	// offer one item; valid stays up across back-to-back items
	task automatic send_sample(logic [31:0] smp, logic last);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1;
		sample    <= smp;
		block_end <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		cfg_we   <= 1;
		cfg_idx  <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
		@(posedge clk);
	endtask

	// drain all expected items, then give a trailing update time to finish
	task automatic wait_idle();
		in_valid <= 0;
		while (sb.scale_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// sample of a chosen amplitude class, so peaks land on both sides of the threshold
	function automatic logic [31:0] pick_sample();
		int unsigned kind;
		int signed amp;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: return $urandom;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			3, 4: begin
				amp = $urandom_range(0, 4000);
				return $urandom_range(0, 1) ? amp : -amp;
			end
			default: begin
				amp = $urandom_range(8000, 300000);
				return $urandom_range(0, 1) ? amp : -amp;
			end
		endcase
	endfunction

	task automatic send_block(int len);
		for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
	endtask

	// receiver: random stalls, a burst stretch, and one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 0;
				out_ready <= 0;
				repeat (600) @(posedge clk);
			end
			gap = rx_burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic [2:0]  modes[9]   = '{MODE_SPIKE, MODE_NONE, MODE_SLOW, MODE_FAST, MODE_DOWN,
			3'd5, 3'd7, MODE_SPIKE, 3'd6};
		logic [6:0]  smooths[9] = '{7'd90, 7'd0, 7'd100, 7'd127, 7'd1, 7'd50, 7'd19, 7'd0, 7'd64};
		logic [7:0]  vols[9]    = '{8'd255, 8'd0, 8'd128, 8'd255, 8'd1, 8'd85, 8'd170, 8'd255, 8'd7};
		logic [19:0] wins[9]    = '{20'd1, 20'd4, 20'd1, 20'hfffff, 20'd12, 20'd2, 20'd30,
			20'd1, 20'haaaaa};
		int len;
		tx_burst = 0; rx_burst = 0; rx_hold_req = 0; stim_done = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, tiny blocks, repeated upward jumps under reset settings but window 1
		write_cfg(REG_WINDOW, 20'd1);
		cfg_we <= 0;
		send_sample(32'h7fffffff, 1);
		send_sample(32'h80000000, 1);
		send_sample(32'h00000000, 0);
		send_sample(32'hffffffff, 1);
		send_sample(32'h80000000, 0);
		send_sample(32'h7fffffff, 1);
		send_sample(32'd4000, 0);
		send_sample(-32'sd12384, 1);        // delta exactly at threshold
		send_sample(32'd16383, 0);
		send_sample(32'd0, 1);              // delta just below threshold
		for (int k = 0; k < 6; k++) begin
			send_sample(32'd9000, 0);       // small peaks push upward jumps of the set point
			send_sample(-32'sd9000, 1);
		end
		send_sample(32'h00000001, 1);
		send_sample(32'hfffffffe, 1);
		wait_idle();

		// random phases, each with its own register settings
		for (int p = 0; p < 9; p++) begin
			write_cfg(REG_FOLLOW_MODE, modes[p]);
			write_cfg(REG_SMOOTHING, smooths[p]);
			write_cfg(REG_CHANNEL_VOL, vols[p]);
			write_cfg(REG_WINDOW, wins[p]);
			cfg_we <= 0;
			tx_burst = (p % 3 == 1);
			rx_burst = (p % 4 == 2);
			if (p == 4) rx_hold_req = 1;
			for (int n = 0; n < 100; n += len) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				send_block(len);
			end
			wait_idle();
		end
		stim_done = 1;
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#30ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
rtl/abpagc_pkg.sv
rtl/abpagc_div.sv
rtl/abpagc_dp.sv
rtl/abpagc_ctrl.sv
rtl/audio_block_peak_agc_unit.sv
tb/sv/testbench.sv
